>>> sv/icmp_rm_pkg.sv
// Shared types and constants for the ICMP reply matcher.
// Depends on nothing; every other file of the block imports it.
package icmp_rm_pkg;

   // Largest packet the byte counter keeps; later bytes are dropped.
   localparam int unsigned MAX_PACKET_BYTES_DEF = 65536;

   // ICMP time-exceeded message with the TTL-exceeded-in-transit code.
   localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
   localparam logic [7:0] CODE_TTL_EXCEEDED  = 8'd0;

   // Offsets inside the headers never exceed 60 + 8 + 60 + 8.
   localparam int unsigned OFF_W          = 8;
   localparam logic [OFF_W-1:0] ICMP_HDR_BYTES = OFF_W'(8);

   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EXPECTED_ID  = 1'b0,
      CSR_EXPECTED_SEQ = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_beat_type;

   typedef struct packed {
      logic matched;
      logic via_ttl_exceeded;
      logic truncated;
   } rsp_beat_type;

   typedef struct packed {
      logic [15:0] expected_id;
      logic [15:0] expected_seq;
   } match_cfg_type;

   // IHL nibble to header length in bytes (nibble times four).
   function automatic logic [5:0] hdr_len(input logic [3:0] nibble);
      hdr_len = {nibble, 2'b00};
   endfunction

endpackage

>>> sv/icmp_rm_parser.sv
// Per-byte header walker of the ICMP reply matcher: packet state and the result logic.
// Depends on icmp_rm_pkg.
module icmp_rm_parser
   import icmp_rm_pkg::*;
#(
   parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          step_en,
   input  req_beat_type  beat,
   input  match_cfg_type cfg,
   output rsp_beat_type  result
);

   localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);
   localparam int unsigned CMP_W = (POS_W > OFF_W) ? POS_W : OFF_W;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [5:0]       outer_ff, outer_in;
   logic [5:0]       inner_ff, inner_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       code_ff, code_in;
   logic [15:0]      id_ff, id_in;
   logic [15:0]      seq_ff, seq_in;

   logic             take;
   logic [CMP_W-1:0] p, hx, base, n, need;
   logic [5:0]       outer_n, inner_n;
   logic [7:0]       type_n, code_n;
   logic [15:0]      id_n, seq_n;
   logic             past_code, ttl_stored, capt_ok, via, trunc;

   always_comb begin
      take    = step_en && (pos_ff < POS_W'(MAX_PACKET_BYTES));
      p       = CMP_W'(pos_ff);
      outer_n = outer_ff;
      if (take && pos_ff == '0) begin
         outer_n = hdr_len(beat.data_byte[3:0]);
      end
      hx = CMP_W'(outer_n);

      type_n = type_ff;
      code_n = code_ff;
      if (take && p == hx) begin
         type_n = beat.data_byte;
      end
      if (take && p == hx + CMP_W'(1)) begin
         code_n = beat.data_byte;
      end

      // Once past the code byte, type and code are already held in the registers.
      past_code  = p >= hx + CMP_W'(2);
      ttl_stored = (type_ff == TYPE_TIME_EXCEEDED) && (code_ff == CODE_TTL_EXCEEDED);

      inner_n = inner_ff;
      if (take && past_code && ttl_stored && p == hx + CMP_W'(ICMP_HDR_BYTES)) begin
         inner_n = hdr_len(beat.data_byte[3:0]);
      end

      base    = ttl_stored ? hx + CMP_W'(ICMP_HDR_BYTES) + CMP_W'(inner_ff) : hx;
      capt_ok = take && past_code && (!ttl_stored || p > hx + CMP_W'(ICMP_HDR_BYTES));

      id_n  = id_ff;
      seq_n = seq_ff;
      if (capt_ok) begin
         if (p == base + CMP_W'(4)) begin
            id_n[15:8] = beat.data_byte;
         end else if (p == base + CMP_W'(5)) begin
            id_n[7:0] = beat.data_byte;
         end else if (p == base + CMP_W'(6)) begin
            seq_n[15:8] = beat.data_byte;
         end else if (p == base + CMP_W'(7)) begin
            seq_n[7:0] = beat.data_byte;
         end
      end

      pos_in = take ? pos_ff + POS_W'(1) : pos_ff;
      n      = CMP_W'(pos_in);

      via  = (n >= hx + CMP_W'(2)) && (type_n == TYPE_TIME_EXCEEDED)
             && (code_n == CODE_TTL_EXCEEDED);
      need = hx + CMP_W'(ICMP_HDR_BYTES);
      if (via) begin
         need = hx + CMP_W'(ICMP_HDR_BYTES) + CMP_W'(inner_n) + CMP_W'(ICMP_HDR_BYTES);
      end
      trunc = (n < need) || (via && (n < hx + CMP_W'(ICMP_HDR_BYTES) + CMP_W'(1)));

      result.matched          = !trunc && (id_n == cfg.expected_id)
                                && (seq_n == cfg.expected_seq);
      result.via_ttl_exceeded = via;
      result.truncated        = trunc;

      outer_in = outer_n;
      inner_in = inner_n;
      type_in  = type_n;
      code_in  = code_n;
      id_in    = id_n;
      seq_in   = seq_n;
      if (step_en && beat.last_byte) begin
         pos_in   = '0;
         outer_in = '0;
         inner_in = '0;
         type_in  = '0;
         code_in  = '0;
         id_in    = '0;
         seq_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         outer_ff <= '0;
         inner_ff <= '0;
         type_ff  <= '0;
         code_ff  <= '0;
         id_ff    <= '0;
         seq_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         outer_ff <= outer_in;
         inner_ff <= inner_in;
         type_ff  <= type_in;
         code_ff  <= code_in;
         id_ff    <= id_in;
         seq_ff   <= seq_in;
      end
   end

   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MAX_PACKET_BYTES))
      else $error("byte count ran past the maximum packet length");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step_en && beat.last_byte |=> pos_ff == '0 && outer_ff == '0 && id_ff == '0)
      else $error("packet state not cleared after the last beat");

   a_trunc_no_match: assert property (@(posedge clock) disable iff (reset)
      step_en && beat.last_byte && result.truncated |-> !result.matched)
      else $error("truncated packet reported as matched");

endmodule

>>> sv/icmp_rm_out_reg.sv
// Result register of the ICMP reply matcher, holding one beat until it is taken.
// Depends on icmp_rm_pkg.
module icmp_rm_out_reg
   import icmp_rm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_beat_type load_data,
   output logic         slot_free,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_beat_type rsp_data
);

   logic         valid_ff, valid_in;
   rsp_beat_type data_ff, data_in;

   always_comb begin
      slot_free = !valid_ff || rsp_ready;
      valid_in  = load || (valid_ff && !rsp_ready);
      data_in   = load ? load_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> sv/icmp_reply_matcher.sv
// Top level of the ICMP reply matcher: input register, configuration registers,
// the header walker and the result register. Depends on icmp_rm_pkg and its submodules.
//
// The block takes a received IPv4 packet one byte per beat on the req_ channel and, on
// the beat flagged as last, returns one rsp_ beat saying whether the probe identifier and
// sequence number found in the ICMP header match the values held in the two configuration
// registers, whether the reply was a TTL-exceeded message (type 11, code 0, in which case
// the quoted inner header is walked to find the original probe header), and whether the
// packet ended before the needed fields arrived. A truncated packet never reports a match.
// Non-last beats produce no result. One byte is accepted every clock cycle; the only
// limit on rate is the result register, so a last beat waits only while an earlier result
// is still held there and not being taken. A last byte first sits in the input register;
// when the result register has room, the parser's result for it is loaded there and
// presented on rsp_. Bytes beyond MAX_PACKET_BYTES are dropped but a last byte still
// closes the packet. The configuration registers (index 0 expected identifier, index 1
// expected sequence number, both with the first wire byte in the upper half) are always
// ready and should be written only while no packet is in progress.
module icmp_reply_matcher
   import icmp_rm_pkg::*;
#(
   parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_beat_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_beat_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Input register: one beat waits here while the parser works on it.
   logic          in_valid_ff, in_valid_in;
   req_beat_type  in_beat_ff, in_beat_in;
   logic          step_en;
   logic          slot_free;
   rsp_beat_type  parse_result;
   match_cfg_type cfg_ff, cfg_in;

   // A byte that is not the last of its packet always moves on; a last byte needs room
   // in the result register.
   always_comb begin
      step_en     = in_valid_ff && (!in_beat_ff.last_byte || slot_free);
      req_ready   = !in_valid_ff || step_en;
      in_valid_in = (req_valid && req_ready) || (in_valid_ff && !step_en);
      in_beat_in  = (req_valid && req_ready) ? req_data : in_beat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_beat_ff <= in_beat_in;
   end

   // Configuration registers: a write is taken on every cycle.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_EXPECTED_ID:  cfg_in.expected_id  = csr_wdata;
            CSR_EXPECTED_SEQ: cfg_in.expected_seq = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   icmp_rm_parser #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .beat    (in_beat_ff),
      .cfg     (cfg_ff),
      .result  (parse_result)
   );

   icmp_rm_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step_en && in_beat_ff.last_byte),
      .load_data (parse_result),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // A new result only follows a last byte leaving the input register.
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(step_en && in_beat_ff.last_byte))
      else $error("result beat without a last byte");

   // A held input beat is not lost or changed while it waits.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step_en |=> in_valid_ff && $stable(in_beat_ff))
      else $error("waiting input beat dropped or altered");

   // A last byte is only passed on when the result register has room.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      step_en && in_beat_ff.last_byte |-> !rsp_valid || rsp_ready)
      else $error("result register overwritten before it was taken");

endmodule
